@@ rtl/dwe_pkg.sv @@
// Package for the deque with erase-by-value block.
// Holds request/response structs, action and status codes, and default sizes.
// No dependencies.
package dwe_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd1;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_ERASE      = 3'd4;
    localparam logic [2:0] ACT_CLEAR      = 3'd5;
    localparam logic [2:0] ACT_DUMP       = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [6:0]         fill_count;
        logic               last;
    } t_rsp;

endpackage

@@ rtl/dwe_ram.sv @@
// Entry store for the deque: one write port, one read port, registered read data.
// Depends on nothing; sized by parameters from the top level.
module dwe_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deque_with_erase_by_value_core.sv @@
// Top level of the bounded deque with erase-by-value; sequencer around one slot adder.
// Depends on dwe_pkg and dwe_ram.
//
// Push, pop, clear and unused codes finish on acceptance; the status result appears
// in the cycle after the request. Erase walks the entries front to back, one per cycle
// through the single RAM read port, then shifts the tail down one slot a cycle.
// Dump reads the first entry on acceptance, then emits one result per cycle, one for
// each held entry. An empty store answers erase or dump in the cycle after the
// request. Results carry a one-cycle strobe and cannot be stalled; busy is high
// while a walk is in progress.
module deque_with_erase_by_value_core #(
    parameter int CAPACITY   = dwe_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = dwe_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  dwe_pkg::t_req i_req,
    output logic          o_rsp_valid,
    output dwe_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM   = SW'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_DUMP   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_held, n_held;
    logic [CW-1:0]         r_c, n_c;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_ra1, r_ra2;
    logic                  r_out_valid, n_out_valid;
    dwe_pkg::t_rsp         r_out, n_out;

    logic                         w_accept;
    logic signed [63:0]           w_val64;
    logic [DATA_WIDTH-1:0]        w_dv;
    logic [DATA_WIDTH-1:0]        w_rd;
    logic signed [DATA_WIDTH-1:0] w_rd_s;
    logic signed [63:0]           w_rd64;
    logic [CW-1:0]                w_c_inc;
    logic [CW-1:0]                w_k;
    logic [SW-1:0]                w_sum;
    logic [AW-1:0]                w_slot;
    logic [AW-1:0]                w_front_dec;
    logic [AW-1:0]                w_front_inc;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [DATA_WIDTH-1:0]        w_wdata;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && (r_state == S_IDLE);

    assign w_val64 = {{32{i_req.value[31]}}, i_req.value};
    assign w_dv    = w_val64[DATA_WIDTH-1:0];
    assign w_rd_s  = w_rd;
    assign w_rd64  = 64'(w_rd_s);
    assign w_c_inc = r_c + 1'b1;

    // shared slot adder: (front + k) mod CAPACITY
    always_comb begin
        if (r_state == S_IDLE) begin
            w_k = (i_req.action == dwe_pkg::ACT_PUSH_BACK) ? r_held : '0;
        end else begin
            w_k = w_c_inc;
        end
    end

    assign w_sum  = SW'(r_front) + SW'(w_k);
    assign w_slot = (w_sum >= CAP_SUM) ? AW'(w_sum - CAP_SUM) : AW'(w_sum);

    assign w_front_dec = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign w_front_inc = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;

    dwe_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_slot),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_held      = r_held;
        n_c         = r_c;
        n_val       = r_val;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = w_slot;
        w_wdata     = w_dv;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_val             = w_dv;
                    n_c               = '0;
                    n_out_valid       = 1'b1;
                    n_out.status      = dwe_pkg::ST_OK;
                    n_out.entry_value = '0;
                    n_out.last        = 1'b1;
                    unique case (i_req.action)
                        dwe_pkg::ACT_PUSH_FRONT: begin
                            if (r_held == CAP_CNT) begin
                                n_out.status = dwe_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_front_dec;
                                n_front = w_front_dec;
                                n_held  = r_held + 1'b1;
                            end
                        end
                        dwe_pkg::ACT_POP_FRONT: begin
                            if (r_held == '0) begin
                                n_out.status = dwe_pkg::ST_EMPTY;
                            end else begin
                                n_front = w_front_inc;
                                n_held  = r_held - 1'b1;
                            end
                        end
                        dwe_pkg::ACT_PUSH_BACK: begin
                            if (r_held == CAP_CNT) begin
                                n_out.status = dwe_pkg::ST_FULL;
                            end else begin
                                w_we   = 1'b1;
                                n_held = r_held + 1'b1;
                            end
                        end
                        dwe_pkg::ACT_POP_BACK: begin
                            if (r_held == '0) begin
                                n_out.status = dwe_pkg::ST_EMPTY;
                            end else begin
                                n_held = r_held - 1'b1;
                            end
                        end
                        dwe_pkg::ACT_ERASE: begin
                            if (r_held == '0) begin
                                n_out.status = dwe_pkg::ST_NOT_FOUND;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SEARCH;
                            end
                        end
                        dwe_pkg::ACT_CLEAR: begin
                            n_held  = '0;
                            n_front = '0;
                        end
                        dwe_pkg::ACT_DUMP: begin
                            if (r_held == '0) begin
                                n_out.status = dwe_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_rd == r_val) begin
                    if (w_c_inc < r_held) begin
                        n_c     = w_c_inc;
                        n_state = S_SHIFT;
                    end else begin
                        n_held            = r_held - 1'b1;
                        n_out_valid       = 1'b1;
                        n_out.status      = dwe_pkg::ST_OK;
                        n_out.entry_value = '0;
                        n_out.last        = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (w_c_inc == r_held) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = dwe_pkg::ST_NOT_FOUND;
                    n_out.entry_value = '0;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_c = w_c_inc;
                end
            end
            S_SHIFT: begin
                // entry c arrives; it moves down into the slot of entry c-1
                w_we    = 1'b1;
                w_waddr = r_ra2;
                w_wdata = w_rd;
                if (w_c_inc == r_held) begin
                    n_held            = r_held - 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.status      = dwe_pkg::ST_OK;
                    n_out.entry_value = '0;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_c = w_c_inc;
                end
            end
            S_DUMP: begin
                n_out_valid       = 1'b1;
                n_out.status      = dwe_pkg::ST_OK;
                n_out.entry_value = w_rd64[31:0];
                n_out.last        = (w_c_inc == r_held);
                if (w_c_inc == r_held) begin
                    n_state = S_IDLE;
                end else begin
                    n_c = w_c_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.fill_count = 7'(n_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_held      <= '0;
            r_c         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_held      <= n_held;
            r_c         <= n_c;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_out <= n_out;
        r_ra1 <= w_slot;
        r_ra2 <= r_ra1;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for deque_with_erase_by_value_core.
// Keeps its own deque model, drives directed and random requests, checks each result.
// Depends on dwe_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CAP         = dwe_pkg::CAPACITY_DEF;
    localparam logic [2:0] ACT_UNUSED  = 3'd7;
    localparam int         STALL_LIMIT = 3000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    dwe_pkg::t_req i_req;
    logic          o_rsp_valid;
    dwe_pkg::t_rsp o_rsp;

    deque_with_erase_by_value_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp)
    );

    logic signed [31:0] deque_mem [CAP];
    logic [5:0]         model_front;
    logic [6:0]         model_count;
    dwe_pkg::t_rsp      pending_rsps [$];
    dwe_pkg::t_rsp      head_rsp;
    int                 fail_count = 0;
    int                 stall_cycles = 0;
    bit                 burst_mode;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic queue_expected(input dwe_pkg::t_rsp rsp);
        pending_rsps.insert(pending_rsps.size(), rsp);
    endtask

    task automatic deque_model_apply(input dwe_pkg::t_req req);
        dwe_pkg::t_rsp rsp;
        int            hit;
        logic [5:0]    slot;
        rsp = '0;
        rsp.last = 1'b1;
        case (req.action)
            dwe_pkg::ACT_PUSH_FRONT: begin
                if (model_count >= CAP) begin
                    rsp.status = dwe_pkg::ST_FULL;
                end else begin
                    model_front = model_front - 6'd1;
                    deque_mem[model_front] = req.value;
                    model_count++;
                end
            end
            dwe_pkg::ACT_POP_FRONT: begin
                if (model_count == 0) begin
                    rsp.status = dwe_pkg::ST_EMPTY;
                end else begin
                    model_front = model_front + 6'd1;
                    model_count--;
                end
            end
            dwe_pkg::ACT_PUSH_BACK: begin
                if (model_count >= CAP) begin
                    rsp.status = dwe_pkg::ST_FULL;
                end else begin
                    slot = model_front + model_count[5:0];
                    deque_mem[slot] = req.value;
                    model_count++;
                end
            end
            dwe_pkg::ACT_POP_BACK: begin
                if (model_count == 0) rsp.status = dwe_pkg::ST_EMPTY;
                else model_count--;
            end
            dwe_pkg::ACT_ERASE: begin
                hit = -1;
                for (int k = 0; k < model_count; k++) begin
                    slot = model_front + 6'(k);
                    if (hit < 0 && deque_mem[slot] == req.value) hit = k;
                end
                if (hit < 0) begin
                    rsp.status = dwe_pkg::ST_NOT_FOUND;
                end else begin
                    for (int j = hit; j + 1 < model_count; j++)
                        deque_mem[model_front + 6'(j)] = deque_mem[model_front + 6'(j + 1)];
                    model_count--;
                end
            end
            dwe_pkg::ACT_CLEAR: begin
                model_count = '0;
                model_front = '0;
            end
            dwe_pkg::ACT_DUMP: begin
                if (model_count == 0) begin
                    rsp.status = dwe_pkg::ST_EMPTY;
                end else begin
                    for (int k = 0; k < model_count; k++) begin
                        rsp.entry_value = deque_mem[model_front + 6'(k)];
                        rsp.fill_count  = model_count;
                        rsp.last        = (k + 1 == model_count);
                        queue_expected(rsp);
                    end
                    return;
                end
            end
            default: ;
        endcase
        rsp.fill_count = model_count;
        queue_expected(rsp);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] rand_value();
        if ($urandom_range(0, 9) < 4) return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        return $signed($urandom());
    endfunction

    function automatic logic signed [31:0] held_value();
        logic [5:0] idx;
        if (model_count == 0) return rand_value();
        idx = 6'($urandom_range(0, model_count - 1));
        return deque_mem[model_front + idx];
    endfunction

    task automatic send_request(input logic [2:0] act, input logic signed [31:0] val);
        dwe_pkg::t_req req;
        int            gap;
        req.action = act;
        req.value  = val;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        @(negedge i_clk);
        while (busy) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        deque_model_apply(req);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_rsps.size() == 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic test_empty_store();
        send_request(dwe_pkg::ACT_POP_FRONT, 32'sd1);
        send_request(dwe_pkg::ACT_POP_BACK, -32'sd1);
        send_request(dwe_pkg::ACT_ERASE, 32'sd0);
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
        send_request(ACT_UNUSED, $signed(32'hFFFF_FFFF));
    endtask

    task automatic test_basic_ops();
        send_request(dwe_pkg::ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(dwe_pkg::ACT_PUSH_BACK, $signed(32'h8000_0000));
        send_request(dwe_pkg::ACT_PUSH_FRONT, -32'sd1);
        send_request(dwe_pkg::ACT_PUSH_BACK, 32'sd0);
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
        send_request(dwe_pkg::ACT_ERASE, $signed(32'h8000_0000));
        send_request(dwe_pkg::ACT_ERASE, 32'sd12345);
        send_request(dwe_pkg::ACT_POP_FRONT, 32'sd0);
        send_request(dwe_pkg::ACT_POP_BACK, 32'sd0);
        send_request(ACT_UNUSED, 32'sd0);
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
        send_request(dwe_pkg::ACT_CLEAR, 32'sd7);
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
    endtask

    task automatic test_erase_duplicates();
        send_request(dwe_pkg::ACT_PUSH_BACK, 32'sd5);
        send_request(dwe_pkg::ACT_PUSH_BACK, 32'sd5);
        send_request(dwe_pkg::ACT_PUSH_BACK, 32'sd9);
        send_request(dwe_pkg::ACT_ERASE, 32'sd5);
        send_request(dwe_pkg::ACT_ERASE, 32'sd9);
        send_request(dwe_pkg::ACT_ERASE, 32'sd5);
        send_request(dwe_pkg::ACT_ERASE, 32'sd5);
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
    endtask

    task automatic test_fill_to_full();
        send_request(dwe_pkg::ACT_CLEAR, 32'sd0);
        while (model_count < CAP)
            send_request($urandom_range(0, 1) ? dwe_pkg::ACT_PUSH_FRONT
                                              : dwe_pkg::ACT_PUSH_BACK, rand_value());
        send_request(dwe_pkg::ACT_PUSH_FRONT, rand_value());
        send_request(dwe_pkg::ACT_PUSH_BACK, rand_value());
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
        send_request(dwe_pkg::ACT_ERASE, held_value());
        send_request(dwe_pkg::ACT_ERASE, held_value());
        send_request(dwe_pkg::ACT_PUSH_BACK, rand_value());
        send_request(dwe_pkg::ACT_PUSH_FRONT, rand_value());
        send_request(dwe_pkg::ACT_PUSH_BACK, rand_value());
        send_request(dwe_pkg::ACT_POP_FRONT, rand_value());
        send_request(dwe_pkg::ACT_POP_BACK, rand_value());
        send_request(dwe_pkg::ACT_DUMP, 32'sd0);
    endtask

    task automatic test_random_mix(input int n_items);
        int bias;
        int push_w;
        int pop_w;
        int r;
        bias = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                bias = $urandom_range(0, 2);
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            push_w = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
            pop_w  = (bias == 1) ? 50 : (bias == 0) ? 10 : 25;
            r = $urandom_range(0, 99);
            if (r < push_w)
                send_request($urandom_range(0, 1) ? dwe_pkg::ACT_PUSH_FRONT
                                                  : dwe_pkg::ACT_PUSH_BACK,
                             rand_value());
            else if (r < push_w + pop_w)
                send_request($urandom_range(0, 1) ? dwe_pkg::ACT_POP_FRONT
                                                  : dwe_pkg::ACT_POP_BACK,
                             rand_value());
            else if (r < 90)
                send_request(dwe_pkg::ACT_ERASE,
                             ($urandom_range(0, 9) < 7) ? held_value() : rand_value());
            else if (r < 96)
                send_request(dwe_pkg::ACT_DUMP, rand_value());
            else if (r < 98)
                send_request(dwe_pkg::ACT_CLEAR, rand_value());
            else
                send_request(ACT_UNUSED, rand_value());
            if (i == n_items / 2) wait_drained();
        end
        burst_mode = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid) begin
            if (pending_rsps.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result %p", $time, o_rsp);
            end else begin
                head_rsp = pending_rsps[0];
                pending_rsps.delete(0);
                if (o_rsp.status !== head_rsp.status) begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_rsp.status, o_rsp.status);
                end
                if (o_rsp.entry_value !== head_rsp.entry_value) begin
                    fail_count++;
                    $display("%0t: entry_value expected %0d actual %0d",
                             $time, head_rsp.entry_value, o_rsp.entry_value);
                end
                if (o_rsp.fill_count !== head_rsp.fill_count) begin
                    fail_count++;
                    $display("%0t: fill_count expected %0d actual %0d",
                             $time, head_rsp.fill_count, o_rsp.fill_count);
                end
                if (o_rsp.last !== head_rsp.last) begin
                    fail_count++;
                    $display("%0t: last expected %0d actual %0d",
                             $time, head_rsp.last, o_rsp.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_rsp_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("deque_with_erase_by_value_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        model_front = '0;
        model_count = '0;
        burst_mode  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_basic_ops();
        test_erase_duplicates();
        wait_drained();
        test_fill_to_full();
        wait_drained();
        test_random_mix(330);

        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_rsps.size() == 0);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("deque_with_erase_by_value_core regression: pass");
        else
            $display("deque_with_erase_by_value_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dwe_pkg.sv
rtl/dwe_ram.sv
rtl/deque_with_erase_by_value_core.sv
verif/testbench.sv
